FILE: rtl/core/tmts_pkg.sv
// Package for the text-mode terminal scroller: beat types, op and register codes,
// sequencer states and character constants. No dependencies.
package tmts_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam int CELL_INDEX_W = 11;
  localparam int POSITION_W   = 11;
  localparam int CELL_W       = 16;
  localparam int COLOR_W      = 4;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [7:0]        NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]        SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] FG_RESET    = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET    = 4'h0;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {BG_RESET, FG_RESET, SPACE_CODE};

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FOREGROUND = 2'd0,
    REG_BACKGROUND = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_LINE_FEED,
    ST_SCROLL,
    ST_BLANK,
    ST_FILL,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [1:0]              op;
    logic [7:0]              char_code;
    logic [CELL_INDEX_W-1:0] cell_index;
  } cmd_item_t;

  typedef struct packed {
    logic [POSITION_W-1:0] cursor_position;
    logic [CELL_W-1:0]     cell_data;
  } rsp_item_t;

endpackage

FILE: rtl/core/text_mode_terminal_scroller_unit.sv
// Text-mode terminal scroller: COLUMNS x ROWS cell store with cursor and scrolling.
// One item at a time. An ordinary put or op 3 goes straight to the reply; a read, a newline
// or a put in the last column passes through a further state first; a newline on the bottom
// row also shifts the store up a row and blanks the bottom row; a clear fills the whole store.
// cmd_ready returns the cycle after the reply is loaded; the load waits while the previous reply stalls.
// Reset: synchronous; the store is wiped to 0x0F20 with cmd_ready low.
module text_mode_terminal_scroller_unit
  import tmts_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_item_t              cmd,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_item_t              rsp,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int SPAN_W     = $clog2(CELL_COUNT + COLUMNS + 1);
  localparam int UW         = (SPAN_W > CELL_INDEX_W) ? SPAN_W : CELL_INDEX_W;

  logic [COLOR_W-1:0] fg, bg;
  logic [UW-1:0]      alu_a, alu_b, alu_limit, alu_sum;
  logic               alu_below;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_FOREGROUND) fg <= cfg_data;
      if (cfg_index == REG_BACKGROUND) bg <= cfg_data;
    end
  end

  tmts_addr_alu #(
    .W(UW)
  ) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .limit (alu_limit),
    .sum   (alu_sum),
    .below (alu_below)
  );

  tmts_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tmts_seq #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS),
    .UW     (UW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .fg        (fg),
    .bg        (bg),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_limit (alu_limit),
    .alu_sum   (alu_sum),
    .alu_below (alu_below),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

FILE: rtl/core/tmts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tmts_addr_alu.sv
// Shared address unit: one adder with a compare of the sum against a limit.
// No dependencies.
module tmts_addr_alu #(
  parameter int W = 16
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] limit,
  output logic [W-1:0] sum,
  output logic         below
);

  logic [W:0] full;

  assign full  = {1'b0, a} + {1'b0, b};
  assign sum   = full[W-1:0];
  assign below = full < {1'b0, limit};

endmodule

FILE: rtl/core/tmts_seq.sv
// Sequencer: cursor state, sweep counter for wipe, fill and scroll, and the result register.
// Depends on tmts_pkg; drives the shared address unit and the cell RAM.
module tmts_seq
  import tmts_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT,
  parameter int UW      = 16,
  localparam int CELL_COUNT = COLUMNS * ROWS,
  localparam int AW = $clog2(CELL_COUNT),
  localparam int CW = $clog2(COLUMNS),
  localparam int RW = $clog2(ROWS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_item_t          cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_item_t          rsp,
  input  logic [COLOR_W-1:0] fg,
  input  logic [COLOR_W-1:0] bg,
  output logic [UW-1:0]      alu_a,
  output logic [UW-1:0]      alu_b,
  output logic [UW-1:0]      alu_limit,
  input  logic [UW-1:0]      alu_sum,
  input  logic               alu_below,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [CELL_W-1:0]  ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  logic [CELL_W-1:0]  ram_rdata
);

  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  seq_state_e          state, state_next;
  cmd_item_t           item;
  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic [UW-1:0]       row_base;
  logic [UW-1:0]       cnt;
  logic                wr_pend;
  logic [AW-1:0]       wr_addr;
  logic                rd_hit;
  logic [CELL_W-1:0]   cell_data;
  logic                rsp_load;
  logic [CELL_W-1:0]   blank;

  assign blank     = {bg, fg, SPACE_CODE};
  assign cmd_ready = (state == ST_IDLE);
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_WIPE:      if (!alu_below) state_next = ST_IDLE;
      ST_IDLE:      if (cmd_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        priority case (item.op)
          OP_PUT: begin
            if (item.char_code == NEWLINE_CODE || col == LAST_COL) begin
              state_next = ST_LINE_FEED;
            end else begin
              state_next = ST_DONE;
            end
          end
          OP_CLEAR: state_next = ST_FILL;
          OP_READ:  state_next = ST_READ;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_READ:      state_next = ST_DONE;
      ST_LINE_FEED: state_next = (row == LAST_ROW) ? ST_SCROLL : ST_DONE;
      ST_SCROLL:    if (!alu_below) state_next = ST_BLANK;
      ST_BLANK:     if (!alu_below) state_next = ST_DONE;
      ST_FILL:      if (!alu_below) state_next = ST_DONE;
      ST_DONE:      if (rsp_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // address unit operands and RAM port
  always_comb begin
    alu_a     = cnt;
    alu_b     = UW'(1);
    alu_limit = UW'(CELL_COUNT);
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = blank;
    ram_raddr = alu_sum[AW-1:0];
    unique case (state)
      ST_WIPE: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_BLANK;
      end
      ST_DISPATCH: begin
        if (item.op == OP_READ) begin
          alu_a = UW'(item.cell_index);
          alu_b = '0;
        end else begin
          alu_a = row_base;
          alu_b = UW'(col);
        end
        ram_we    = (item.op == OP_PUT) && (item.char_code != NEWLINE_CODE);
        ram_waddr = alu_sum[AW-1:0];
        ram_wdata = {bg, fg, item.char_code};
      end
      ST_LINE_FEED: begin
        alu_a = row_base;
        alu_b = UW'(COLUMNS);
      end
      ST_SCROLL: begin
        // read one row below, write the previous read back one row up
        alu_b     = UW'(COLUMNS);
        ram_we    = wr_pend;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata;
      end
      ST_BLANK, ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_DONE: begin
        alu_a = row_base;
        alu_b = UW'(col);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WIPE;
      cnt       <= '0;
      row       <= '0;
      col       <= '0;
      row_base  <= '0;
      wr_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= (state == ST_SCROLL) && alu_below;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_WIPE, ST_BLANK, ST_FILL: begin
          if (alu_below) cnt <= alu_sum;
        end
        ST_DISPATCH: begin
          if (item.op == OP_PUT && item.char_code != NEWLINE_CODE) begin
            col <= (col == LAST_COL) ? col : col + CW'(1);
          end
          if (item.op == OP_CLEAR) begin
            cnt      <= '0;
            row      <= '0;
            col      <= '0;
            row_base <= '0;
          end
        end
        ST_LINE_FEED: begin
          col <= '0;
          cnt <= '0;
          if (row != LAST_ROW) begin
            row      <= row + RW'(1);
            row_base <= alu_sum;
          end
        end
        ST_SCROLL: begin
          if (alu_below) cnt <= cnt + UW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      item <= cmd;
    end
    if (state == ST_SCROLL) begin
      wr_addr <= cnt[AW-1:0];
    end
    if (state == ST_DISPATCH) begin
      rd_hit    <= (item.op == OP_READ) && alu_below;
      cell_data <= '0;
    end
    if (state == ST_READ && rd_hit) begin
      cell_data <= ram_rdata;
    end
    if (rsp_load) begin
      rsp.cursor_position <= alu_sum[POSITION_W-1:0];
      rsp.cell_data       <= cell_data;
    end
  end

endmodule

FILE: tb/text_mode_terminal_scroller_checker.sv
// Reply checker for the text-mode terminal scroller: mirrors the cell store, cursor and
// colour registers, predicts one reply per command beat and compares it field by field.
// Depends on tmts_pkg for the beat types, op and register codes.
`timescale 1ns / 100ps

module text_mode_terminal_scroller_checker
  import tmts_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  logic                   cmd_ready,
  input  cmd_item_t              cmd,
  input  logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  rsp_item_t              rsp,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_data,
  output int unsigned            failures,
  output int unsigned            pending,
  output int unsigned            replies_checked,
  output int unsigned            scrolls
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [CELL_W-1:0]  screen [CELLS];
  int unsigned        row;
  int unsigned        col;
  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  rsp_item_t          predicted_reports [$];
  rsp_item_t          due;

  function automatic logic [CELL_W-1:0] blank();
    return {bg, fg, SPACE_CODE};
  endfunction

  function automatic void fill_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = blank();
  endfunction

  function automatic void line_feed();
    col = 0;
    if (row + 1 >= ROWS) begin
      // shift every row up by one and blank the bottom row
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen[i] = blank();
      row = ROWS - 1;
      scrolls++;
    end else begin
      row++;
    end
  endfunction

  function automatic rsp_item_t predict_report(cmd_item_t c);
    rsp_item_t   r;
    int unsigned at;
    r.cell_data = '0;
    case (c.op)
      OP_PUT: begin
        if (c.char_code == NEWLINE_CODE) begin
          line_feed();
        end else begin
          at = row * COLUMNS + col;
          if (at < CELLS) screen[at] = {bg, fg, c.char_code};
          col++;
          if (col >= COLUMNS) line_feed();
        end
      end
      OP_CLEAR: begin
        fill_screen();
        row = 0;
        col = 0;
      end
      OP_READ: begin
        // out-of-range addresses read as zero
        if (c.cell_index < CELLS) r.cell_data = screen[c.cell_index];
      end
      default: ;
    endcase
    r.cursor_position = POSITION_W'(row * COLUMNS + col);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fg = FG_RESET;
      bg = BG_RESET;
      row = 0;
      col = 0;
      fill_screen();
      predicted_reports.delete();
      failures = 0;
      pending = 0;
      replies_checked = 0;
      scrolls = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FOREGROUND: fg = cfg_data;
          REG_BACKGROUND: bg = cfg_data;
          default: ;
        endcase
      end
      // check the reply beat before queueing a new command: replies always lag
      if (rsp_valid && rsp_ready) begin
        if (predicted_reports.size() == 0) begin
          $error("reply beat with none outstanding: cursor_position %0d, cell_data %h",
                 rsp.cursor_position, rsp.cell_data);
          failures++;
        end else begin
          due = predicted_reports.pop_front();
          if (rsp.cursor_position !== due.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d",
                   due.cursor_position, rsp.cursor_position);
            failures++;
          end
          if (rsp.cell_data !== due.cell_data) begin
            $error("cell_data: expected %h, got %h", due.cell_data, rsp.cell_data);
            failures++;
          end
          replies_checked++;
        end
      end
      if (cmd_valid && cmd_ready) predicted_reports.push_back(predict_report(cmd));
      pending = predicted_reports.size();
    end
  end

endmodule

FILE: tb/tb_text_mode_terminal_scroller_unit.sv
// Testbench top for text_mode_terminal_scroller_unit: clock, reset, command and colour
// stimulus, reply back-pressure and the verdict. Checking lives in
// text_mode_terminal_scroller_checker; types come from tmts_pkg.
`timescale 1ns / 100ps

module tb_text_mode_terminal_scroller_unit
  import tmts_pkg::*;
();

  localparam int COLUMNS = COLUMNS_DEFAULT;
  localparam int ROWS    = ROWS_DEFAULT;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam logic [1:0]             OP_NOP       = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int MAX_INDEX       = 2 ** CELL_INDEX_W - 1;
  localparam int PHASE_ITEMS     = 72;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int STALL_LIMIT     = 25000;
  localparam int TAIL_CYCLES     = 40;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_ready;
  cmd_item_t              cmd = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  rsp_item_t              rsp;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]     cfg_data = '0;

  int unsigned watch_failures;
  int unsigned watch_pending;
  int unsigned watch_replies;
  int unsigned watch_scrolls;

  int unsigned commands_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_off_req = 1'b0;

  always #6 clk = ~clk;

  text_mode_terminal_scroller_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  text_mode_terminal_scroller_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) watch (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .failures       (watch_failures),
    .pending        (watch_pending),
    .replies_checked(watch_replies),
    .scrolls        (watch_scrolls)
  );

  function automatic cmd_item_t make_cmd(input logic [1:0] op, input logic [7:0] ch,
                                         input logic [CELL_INDEX_W-1:0] idx);
    cmd_item_t c;
    c.op = op;
    c.char_code = ch;
    c.cell_index = idx;
    return c;
  endfunction

  // Offer one command beat; open a new burst with a random gap when the last one is spent.
  task automatic offer(input cmd_item_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd <= item;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    if (item.op != OP_NOP) commands_sent++;
  endtask

  // Hold the sender until every outstanding reply has been checked.
  task automatic drain();
    cmd_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (watch_pending != 0) @(posedge clk);
  endtask

  task automatic program_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                                input bit poke_spares);
    cfg_write <= 1'b1;
    cfg_index <= REG_FOREGROUND;
    cfg_data <= fg;
    @(posedge clk);
    cfg_index <= REG_BACKGROUND;
    cfg_data <= bg;
    @(posedge clk);
    if (poke_spares) begin
      // indexes past the colour registers must be dropped
      cfg_index <= REG_SPARE_LO;
      cfg_data <= ~fg;
      @(posedge clk);
      cfg_index <= REG_SPARE_HI;
      cfg_data <= ~bg;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Mostly text lines ending in a newline, so the cursor walks down to the bottom row
  // and scrolls; reads, clears and stray beats mixed in.
  task automatic run_traffic(input int unsigned quota);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  ch;
    logic [CELL_INDEX_W-1:0] idx;
    goal = commands_sent + quota;
    while (commands_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 64) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(COLUMNS - 4, COLUMNS + 4)
                                           : $urandom_range(0, 4);
        repeat (len) begin
          ch = 8'($urandom_range(0, 255));
          if (ch == NEWLINE_CODE) ch = SPACE_CODE;
          offer(make_cmd(OP_PUT, ch, CELL_INDEX_W'($urandom_range(0, MAX_INDEX))));
        end
        offer(make_cmd(OP_PUT, NEWLINE_CODE, CELL_INDEX_W'($urandom_range(0, MAX_INDEX))));
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0: idx = CELL_INDEX_W'($urandom_range(0, 2 * COLUMNS - 1));
            1: idx = CELL_INDEX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
            2: idx = CELL_INDEX_W'($urandom_range(CELLS, MAX_INDEX));
            default: idx = CELL_INDEX_W'($urandom_range(0, MAX_INDEX));
          endcase
          offer(make_cmd(OP_READ, 8'($urandom_range(0, 255)), idx));
        end
      end else if (pick < 87) begin
        offer(make_cmd(OP_CLEAR, 8'($urandom_range(0, 255)),
                       CELL_INDEX_W'($urandom_range(0, MAX_INDEX))));
      end else if (pick < 91) begin
        offer(make_cmd(OP_NOP, 8'($urandom_range(0, 255)),
                       CELL_INDEX_W'($urandom_range(0, MAX_INDEX))));
      end else begin
        offer(make_cmd(OP_PUT, 8'($urandom_range(0, 255)),
                       CELL_INDEX_W'($urandom_range(0, MAX_INDEX))));
      end
    end
  endtask

  // Reply side: steady, stalled or ragged stretches, plus one long hold-off on request.
  initial begin : reply_sink
    int unsigned span;
    int unsigned style;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(1, 40);
        style = $urandom_range(0, 3);
        repeat (span) begin
          case (style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'b0;
            default: rsp_ready <= 1'($urandom_range(0, 1));
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("text_mode_terminal_scroller_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset colours: blank store, range edges, ignored fields, stray op, newline, clear
    offer(make_cmd(OP_READ, 8'h00, 11'd0));
    offer(make_cmd(OP_READ, 8'h00, CELL_INDEX_W'(CELLS - 1)));
    offer(make_cmd(OP_READ, 8'h00, CELL_INDEX_W'(CELLS)));
    offer(make_cmd(OP_READ, 8'h00, CELL_INDEX_W'(MAX_INDEX)));
    offer(make_cmd(OP_PUT, 8'h00, 11'd0));
    offer(make_cmd(OP_PUT, 8'hFF, 11'd0));
    offer(make_cmd(OP_PUT, 8'h41, CELL_INDEX_W'(MAX_INDEX)));
    offer(make_cmd(OP_NOP, 8'hFF, CELL_INDEX_W'(MAX_INDEX)));
    offer(make_cmd(OP_READ, 8'hFF, 11'd0));
    offer(make_cmd(OP_READ, 8'h00, 11'd1));
    offer(make_cmd(OP_PUT, NEWLINE_CODE, CELL_INDEX_W'(MAX_INDEX)));
    offer(make_cmd(OP_READ, 8'hFF, 11'd2));
    offer(make_cmd(OP_CLEAR, 8'hFF, CELL_INDEX_W'(MAX_INDEX)));
    offer(make_cmd(OP_READ, 8'h00, 11'd1));
    drain();

    // opposite colour extremes: written cells and blanks take the new attribute
    program_colors(4'h0, 4'hF, 1'b1);
    offer(make_cmd(OP_PUT, 8'h7E, 11'd0));
    offer(make_cmd(OP_READ, 8'h00, 11'd0));
    offer(make_cmd(OP_CLEAR, 8'h00, 11'd0));
    offer(make_cmd(OP_READ, 8'h00, 11'd5));
    drain();

    program_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)), 1'b0);
    run_traffic(PHASE_ITEMS);
    drain();

    // long reply hold-off while commands keep coming
    program_colors(4'hF, 4'hF, 1'b0);
    hold_off_req = 1'b1;
    run_traffic(PHASE_ITEMS);
    drain();

    program_colors(4'h0, 4'h0, 1'b1);
    run_traffic(PHASE_ITEMS);
    drain();

    program_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)), 1'b0);
    run_traffic(PHASE_ITEMS);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d commands, checked %0d replies; %0d scrolls seen.",
             commands_sent, watch_replies, watch_scrolls);
    $display("Colour settings included both extremes and ignored register indexes.");
    if (watch_failures == 0 && watch_pending == 0) begin
      $display("text_mode_terminal_scroller_unit: match");
    end else begin
      $display("text_mode_terminal_scroller_unit: mismatch");
    end
    $finish;
  end

endmodule
